>>> sv/mxs_pkg.sv
// mxs_pkg: shared types and constants for the maximum subarray XOR block.
// Used by mxs_front, mxs_back and max_xor_subarray; depends on nothing.
`default_nettype none

package mxs_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int MAX_ITEMS   = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] max_xor;
    logic                         overflow;
  } out_t;

  typedef struct packed {
    logic valid;
    in_t  item;
  } front_status_t;

endpackage

`default_nettype wire

>>> sv/mxs_ram.sv
// mxs_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module mxs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/mxs_front.sv
// mxs_front: accepts requests and holds them in a short queue for the back end.
// Depends on mxs_pkg.
`default_nettype none

module mxs_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire mxs_pkg::in_t          item,
  output mxs_pkg::front_status_t     q,
  input  wire logic                  take
);

  localparam int QD = mxs_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int FW = $clog2(QD + 1);

  mxs_pkg::in_t  slot [QD];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign item_stall = (fill == FW'(QD));
  assign push       = item_valid && !item_stall;
  assign pop        = take && (fill != '0);

  assign q.valid = (fill != '0);
  assign q.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item;
    end
  end

endmodule

`default_nettype wire

>>> sv/mxs_back.sv
// mxs_back: prefix XOR engine; scans stored prefixes and emits the record result.
// Depends on mxs_pkg and mxs_ram.
`default_nettype none

module mxs_back #(
  parameter int MAX_ITEMS = mxs_pkg::MAX_ITEMS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mxs_pkg::front_status_t q,
  output logic                       take,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output mxs_pkg::out_t              result
);

  localparam int DW = mxs_pkg::DATA_WIDTH;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state;
  logic signed [DW-1:0] prefix;
  logic signed [DW-1:0] prefix_next;
  logic signed [DW-1:0] best;
  logic signed [DW-1:0] cand;
  logic [CW-1:0]        count;
  logic [CW-1:0]        scan_idx;
  logic [CW-1:0]        scan_limit;
  logic                 rd_pend;
  logic                 last_pend;
  logic                 dropped;
  logic                 we;
  logic                 issue;
  logic                 out_free;
  logic [DW-1:0]        rdata;

  assign take        = (state == ST_IDLE) && q.valid;
  assign prefix_next = prefix ^ q.item.value;
  assign we          = take && (count != CW'(MAX_ITEMS));
  assign issue       = (state == ST_SCAN) && (scan_idx != scan_limit);
  assign cand        = prefix ^ $signed(rdata);
  assign out_free    = !result_valid || !result_stall;

  mxs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (prefix_next),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prefix       <= '0;
      best         <= mxs_pkg::INT_MIN;
      count        <= '0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      last_pend    <= 1'b0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      rd_pend <= issue;
      if (rd_pend && (cand > best)) begin
        best <= cand;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            last_pend <= q.item.last;
            if (we) begin
              prefix     <= prefix_next;
              count      <= count + 1'b1;
              scan_idx   <= '0;
              scan_limit <= count;
              if (prefix_next > best) begin
                best <= prefix_next;
              end
              if (count != '0) begin
                state <= ST_SCAN;
              end else if (q.item.last) begin
                state <= ST_EMIT;
              end
            end else begin
              dropped <= 1'b1;
              if (q.item.last) begin
                state <= ST_EMIT;
              end
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!rd_pend) begin
            state <= last_pend ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            prefix       <= '0;
            best         <= mxs_pkg::INT_MIN;
            count        <= '0;
            dropped      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      result.max_xor  <= best;
      result.overflow <= dropped;
    end
  end

endmodule

`default_nettype wire

>>> sv/max_xor_subarray.sv
// max_xor_subarray: maximum XOR over any contiguous run of a record of signed words.
// Input channel item (value, last) and output channel result (max_xor, overflow),
// both valid/stall. A result leaves once per record, after the word flagged last.
// Words beyond MAX_ITEMS in one record are dropped and the overflow bit is set.
// An accepted word enters a two-entry queue, so item_stall rises only when full;
// the back end takes it from the queue's registers once it is idle.
// The back end takes one word at a time: it folds the word into the running
// prefix and stores it, then makes one prefix-store read per earlier word of the
// record, waits for the last read to return and leaves the scan. The first word
// of a record needs no scan. The scan reads one prefix at a time through the
// store's single read port. After the last word the back end loads the result
// register in ST_EMIT. A stalled result holds in its register; the back end then
// waits at the next record end while the queue takes words until it is full.
// Reset (rst, synchronous) empties the queue, drops any pending result and clears
// the record state; the prefix store needs no clearing pass.
// Depends on mxs_pkg, mxs_front, mxs_back, mxs_ram.
`default_nettype none

module max_xor_subarray #(
  parameter int MAX_ITEMS = mxs_pkg::MAX_ITEMS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire mxs_pkg::in_t item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output mxs_pkg::out_t     result
);

  mxs_pkg::front_status_t q;
  logic                   take;

  mxs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q          (q),
    .take       (take)
  );

  mxs_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q            (q),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("outputs not cleared after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (!rst && item_valid && !item_stall) |=> q.valid)
    else $error("accepted request missing from queue");

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> q.valid)
    else $error("back end took from an empty queue");

endmodule

`default_nettype wire
